// File: src/budgeted_identity_admission_top_defines.svh
// Assertion macros shared by the admission block RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef BUDGETED_IDENTITY_ADMISSION_TOP_DEFINES_SVH
`define BUDGETED_IDENTITY_ADMISSION_TOP_DEFINES_SVH

// cond must hold whenever ante holds, same cycle
`define BIA_ASSERT_SAME(lbl, ante, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cond)) \
        else $error("bia assertion failed");

// cond must hold in the cycle after ante
`define BIA_ASSERT_NEXT(lbl, ante, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cond)) \
        else $error("bia assertion failed");

// cond must never hold
`define BIA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bia assertion failed");

`endif

// File: src/bia_pkg.sv
// Shared constants, codes and controller/datapath types for the admission block.
// No dependencies.
package bia_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int PROBE_LIMIT = 8;
    localparam int MAX_KIND    = 3;
    localparam int CONSUMERS   = 4;
    localparam int BUDGET_MAX  = 64;

    localparam int SHIFT_A = 7;
    localparam int SHIFT_B = 15;

    localparam int REQ_W    = 2;
    localparam int OBJ_W    = 32;
    localparam int KIND_W   = 3;
    localparam int CTX_W    = 2;
    localparam int CONS_W   = 3;
    localparam int BUDGET_W = 7;
    localparam int SALT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int CIDX_W = $clog2(CONSUMERS);
    localparam int USED_W = $clog2(BUDGET_MAX + 1);

    localparam logic [BUDGET_W-1:0] BUDGET_RST = BUDGET_W'(8);
    localparam logic [SALT_W-1:0]   SALT_RST   = 32'd2654435761;

    typedef enum logic [REQ_W-1:0] {
        REQ_DRAW  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_code_t;

    typedef enum logic [CTX_W-1:0] {
        CTX_NONE   = 2'd0,
        CTX_REFL   = 2'd1,
        CTX_SHADOW = 2'd2,
        CTX_RSVD   = 2'd3
    } ctx_code_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SALT   = 2'd2;

    typedef struct packed {
        logic [OBJ_W-1:0]     obj;
        logic [KIND_W-1:0]    kind;
        logic [CONSUMERS-1:0] mask;
        logic                 adm;
    } slot_t;

    // controller -> datapath
    typedef struct packed {
        logic cap;         // capture request
        logic hash;        // form home slot, apply frame tick
        logic rd;          // read slot at probe address
        logic probe_next;  // advance probe
        logic commit;      // hit or claim: update slot and result
        logic ovf;         // probe limit reached
        logic load_out;    // move result to output register
    } bia_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_lookup;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic out_free;
    } bia_sts_t;

endpackage

// File: src/bia_ifs.sv
// Handshake channel interfaces: request, result and configuration write.
// Depends on bia_pkg.
interface bia_req_if;
    logic                        valid;
    logic                        ready;
    logic [bia_pkg::REQ_W-1:0]   req_type;
    logic [bia_pkg::OBJ_W-1:0]   object_id;
    logic [bia_pkg::KIND_W-1:0]  kind;
    logic [bia_pkg::CTX_W-1:0]   context_req;
    logic [bia_pkg::CONS_W-1:0]  consumer;

    modport source (output valid, req_type, object_id, kind, context_req, consumer,
                    input ready);
    modport sink   (input valid, req_type, object_id, kind, context_req, consumer,
                    output ready);
endinterface

interface bia_rsp_if;
    logic valid;
    logic ready;
    logic defer;
    logic first_use;
    logic tracked;
    logic overflow;
    logic armed;

    modport source (output valid, defer, first_use, tracked, overflow, armed,
                    input ready);
    modport sink   (input valid, defer, first_use, tracked, overflow, armed,
                    output ready);
endinterface

interface bia_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bia_pkg::CFG_IDX_W-1:0]    index;
    logic [bia_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/budgeted_identity_admission_top.sv
// Identity table with per-frame admission budget: top level.
// Depends on bia_pkg, the channel interfaces, bia_ctrl and bia_datapath.
//
// One request in, one result out, one request at a time. A request is
// taken only while the sequencer is idle; its result sits in an output
// register, so a new request may be taken while that result still waits.
// From acceptance, a request that needs no table lookup (frame tick,
// inactive or untracked draw, bad consumer, unused code) passes the
// hash state and then the done state, which waits until the output
// register is free. Each probed slot (up to PROBE_LIMIT) adds a read and
// a check state: the slot table has a registered read port, and the
// compare and update happen in the following cycle. The home slot is the
// object id mixed by two xor-shifts (7, then 15) xored with kind times the
// salt register, masked to the table size; probing walks forward with
// wrap. Table occupancy is tracked with one valid flop per slot, cleared
// directly by reset, so there is no clearing pass and the block is ready
// right after reset. Configuration writes (enable, frame_budget,
// hash_salt) are always accepted and must only be issued while idle.
// A frame_budget above the budget ceiling admits nothing.

module budgeted_identity_admission_top (
    input  logic       clk,
    input  logic       rst_n,
    bia_cfg_if.sink    cfg,
    bia_req_if.sink    req,
    bia_rsp_if.source  rsp
);
    import bia_pkg::*;

    bia_cmd_t cmd;
    bia_sts_t sts;
    logic     in_ready;

    // request ready comes from the sequencer
    assign req.ready = in_ready;

    bia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, hashing, budget and result registers
    bia_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// File: src/bia_ctrl.sv
// Request sequencer: capture, hash, probe loop, commit, result hand-off.
// Depends on bia_pkg and the assertion macro header.
`include "budgeted_identity_admission_top_defines.svh"

module bia_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bia_pkg::bia_sts_t sts,
    output bia_pkg::bia_cmd_t cmd
);
    import bia_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HASH = 5'b00010,
        ST_RD   = 5'b00100,
        ST_CHK  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = sts.need_lookup ? ST_RD : ST_DONE;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.slot_empty || sts.slot_match)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.probe_last)
                begin
                    cmd.ovf    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `BIA_ASSERT_NEVER(a_commit_vs_step, cmd.commit && (cmd.probe_next || cmd.ovf))
    `BIA_ASSERT_NEXT(a_read_then_check, state_reg == ST_RD, state_reg == ST_CHK)
    `BIA_ASSERT_SAME(a_load_needs_room, cmd.load_out, sts.out_free)

endmodule

// File: src/bia_datapath.sv
// Table storage, hash, probe address, budget and result registers.
// Depends on bia_pkg, the channel interfaces and the assertion macro header.
`include "budgeted_identity_admission_top_defines.svh"

module bia_datapath (
    input  logic              clk,
    input  logic              rst_n,
    bia_cfg_if.sink           cfg,
    bia_req_if.sink           req,
    bia_rsp_if.source         rsp,
    input  bia_pkg::bia_cmd_t cmd,
    output bia_pkg::bia_sts_t sts
);
    import bia_pkg::*;

    // configuration
    logic                 enable_reg;
    logic [BUDGET_W-1:0]  budget_reg;
    logic [SALT_W-1:0]    salt_reg;

    // captured request
    req_code_t            cap_req_reg;
    logic [OBJ_W-1:0]     cap_obj_reg;
    logic [KIND_W-1:0]    cap_kind_reg;
    logic [CTX_W-1:0]     cap_ctx_reg;
    logic [CONS_W-1:0]    cap_cons_reg;

    // probe
    logic [SLOT_W-1:0]    addr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    slot_t                rd_slot_reg;
    logic                 rd_vld_reg;

    // table
    slot_t                slot_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] slot_vld_reg;

    // budget / sticky flag
    logic [USED_W-1:0]    used_reg;
    logic                 armed_reg;

    // result under construction
    logic                 res_defer_reg;
    logic                 res_first_reg;
    logic                 res_tracked_reg;
    logic                 res_ovf_reg;

    // output register
    logic                 out_valid_reg;
    logic                 out_defer_reg;
    logic                 out_first_reg;
    logic                 out_tracked_reg;
    logic                 out_ovf_reg;
    logic                 out_armed_reg;

    logic [OBJ_W+KIND_W-1:0] prod_full;
    logic [OBJ_W-1:0]     h1;
    logic [OBJ_W-1:0]     h2;
    logic [OBJ_W-1:0]     hash_val;
    logic                 id_ok;
    logic                 ctx_active;
    logic                 cons_ok;
    logic [BUDGET_W-1:0]  budget_eff;
    logic                 can_admit;
    logic [CIDX_W-1:0]    cidx;
    slot_t                slot_wr;
    logic                 c_defer;
    logic                 c_first;
    logic                 c_admit;

    assign cfg.ready = 1'b1;

    // hash: object mix then kind times salt
    assign prod_full = {{OBJ_W{1'b0}}, cap_kind_reg} * {{KIND_W{1'b0}}, salt_reg};
    assign h1        = cap_obj_reg ^ (cap_obj_reg >> SHIFT_A);
    assign h2        = h1 ^ (h1 >> SHIFT_B);
    assign hash_val  = h2 ^ prod_full[OBJ_W-1:0];

    assign id_ok      = (cap_obj_reg != '0) && (cap_kind_reg != '0)
                        && (cap_kind_reg <= KIND_W'(MAX_KIND));
    assign ctx_active = (cap_ctx_reg == CTX_REFL) || (cap_ctx_reg == CTX_SHADOW);
    assign cons_ok    = (cap_cons_reg != '0) && (int'(cap_cons_reg) < CONSUMERS);

    always_comb
    begin
        sts.need_lookup = id_ok
            && (((cap_req_reg == REQ_DRAW) && enable_reg && ctx_active)
                || ((cap_req_reg == REQ_QUERY) && cons_ok));
        sts.slot_empty  = !rd_vld_reg;
        sts.slot_match  = rd_vld_reg && (rd_slot_reg.obj == cap_obj_reg)
                          && (rd_slot_reg.kind == cap_kind_reg);
        sts.probe_last  = (cnt_reg == CNT_W'(PROBE_LIMIT - 1));
        sts.out_free    = !out_valid_reg || rsp.ready;
    end

    // out-of-range budget counts as zero
    assign budget_eff = (int'(budget_reg) > BUDGET_MAX) ? '0 : budget_reg;
    assign can_admit  = (32'(used_reg) < 32'(budget_eff));
    assign cidx       = cap_cons_reg[CIDX_W-1:0];

    // slot update for hit or fresh claim
    always_comb
    begin
        slot_wr.obj  = cap_obj_reg;
        slot_wr.kind = cap_kind_reg;
        slot_wr.mask = rd_vld_reg ? rd_slot_reg.mask : '0;
        slot_wr.adm  = rd_vld_reg ? rd_slot_reg.adm  : 1'b0;
        c_defer = 1'b0;
        c_first = 1'b0;
        c_admit = 1'b0;
        if (cap_req_reg == REQ_DRAW)
        begin
            if (!slot_wr.adm)
            begin
                if (can_admit)
                begin
                    slot_wr.adm = 1'b1;
                    c_admit     = 1'b1;
                end
                else
                begin
                    c_defer = 1'b1;
                end
            end
        end
        else if (!slot_wr.mask[cidx])
        begin
            slot_wr.mask[cidx] = 1'b1;
            c_first            = 1'b1;
        end
    end

    // table array, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            slot_mem[addr_reg] <= slot_wr;
        end
        if (cmd.rd)
        begin
            rd_slot_reg <= slot_mem[addr_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            cap_req_reg     <= req_code_t'(req.req_type);
            cap_obj_reg     <= req.object_id;
            cap_kind_reg    <= req.kind;
            cap_ctx_reg     <= req.context_req;
            cap_cons_reg    <= req.consumer;
            res_defer_reg   <= 1'b0;
            res_first_reg   <= 1'b0;
            res_tracked_reg <= 1'b0;
            res_ovf_reg     <= 1'b0;
        end
        if (cmd.hash)
        begin
            addr_reg <= hash_val[SLOT_W-1:0];
            cnt_reg  <= '0;
        end
        if (cmd.probe_next)
        begin
            addr_reg <= addr_reg + SLOT_W'(1);
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.commit)
        begin
            res_tracked_reg <= 1'b1;
            res_defer_reg   <= c_defer;
            res_first_reg   <= c_first;
        end
        if (cmd.ovf)
        begin
            res_ovf_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_defer_reg   <= res_defer_reg;
            out_first_reg   <= res_first_reg;
            out_tracked_reg <= res_tracked_reg;
            out_ovf_reg     <= res_ovf_reg;
            out_armed_reg   <= armed_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            budget_reg    <= BUDGET_RST;
            salt_reg      <= SALT_RST;
            slot_vld_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            used_reg      <= '0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_ENABLE: enable_reg <= cfg.data[0];
                    CFG_BUDGET: budget_reg <= cfg.data[BUDGET_W-1:0];
                    CFG_SALT:   salt_reg   <= cfg.data[SALT_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.rd)
            begin
                rd_vld_reg <= slot_vld_reg[addr_reg];
            end
            if (cmd.commit)
            begin
                slot_vld_reg[addr_reg] <= 1'b1;
                if (c_admit)
                begin
                    used_reg <= used_reg + USED_W'(1);
                end
                if (c_defer)
                begin
                    armed_reg <= 1'b1;
                end
            end
            if (cmd.hash && (cap_req_reg == REQ_TICK) && enable_reg)
            begin
                used_reg <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.defer     = out_defer_reg;
    assign rsp.first_use = out_first_reg;
    assign rsp.tracked   = out_tracked_reg;
    assign rsp.overflow  = out_ovf_reg;
    assign rsp.armed     = out_armed_reg;

    `BIA_ASSERT_NEVER(a_used_in_range, 32'(used_reg) > BUDGET_MAX)
    `BIA_ASSERT_NEXT(a_armed_sticky, armed_reg, armed_reg)
    `BIA_ASSERT_SAME(a_defer_tracked, cmd.load_out && res_defer_reg, res_tracked_reg)
    `BIA_ASSERT_NEVER(a_ovf_untracked, cmd.load_out && res_ovf_reg && res_tracked_reg)

endmodule
